@@ src/price_level_order_book_unit_macros.svh @@
// assertion macros for the price level order book checker
`ifndef PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH

// property that holds at every edge out of reset
`define PLOB_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("order book check failed");

// property that holds in the cycle after a trigger
`define PLOB_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("order book check failed");

`endif

@@ src/plob_pkg.sv @@
// shared types and constants of the price level order book
package plob_pkg;

  localparam int MAX_ORDERS_D = 1024;
  localparam int MAX_LEVELS_D = 64;
  localparam int MAX_DEPTH_D  = 16;
  localparam int PRICE_BITS_D = 32;
  localparam int QTY_BITS_D   = 32;
  localparam int LQ_W         = 42;
  localparam int ID_W         = 64;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_ORD_FULL = 3'd2,
    ST_LVL_FULL = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_DEPTH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROW_NOP,
    ROW_ADD,
    ROW_REM,
    ROW_ROT
  } row_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CHECK,
    S_APPLY,
    S_RESP,
    S_DEPTH
  } state_t;

  typedef struct packed {
    logic hit_any;
    logic full;
    logic head_occ;
    logic next_occ;
  } row_stat_t;

endpackage

@@ src/price_level_order_book_unit.sv @@
// top level of the price level order book
// Input channel (in_valid/in_ready) takes one request: add, cancel or depth
// query. The block works on one request at a time; in_ready is high only
// while it is idle, and an output register holds the last result.
// Add and cancel search the order table one entry per cycle up to the
// highest slot ever used, then, unless the request fails, update the
// level row in the apply state; the single result has last set, and the
// next request is taken only once the block is back in idle.
// A depth query rotates the chosen side's cell row once around, one cell a
// cycle while the output is not stalled, one result per level with last on
// the final one, or one empty result when no level is reported.
// Results are taken on out_valid/out_ready; a stalled receiver holds the
// result in the output register and the block waits before the next one.
// Reset empties both level rows and the order table at once (no sweep);
// table contents are only read below the high-water mark.
module price_level_order_book_unit #(
  parameter int MAX_ORDERS = plob_pkg::MAX_ORDERS_D,
  parameter int MAX_LEVELS = plob_pkg::MAX_LEVELS_D,
  parameter int MAX_DEPTH  = plob_pkg::MAX_DEPTH_D,
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_D,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] order_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [4:0]  depth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] best_bid,
  output logic        bid_present,
  output logic [31:0] best_ask,
  output logic        ask_present,
  output logic [32:0] mid_sum,
  output logic [31:0] level_price,
  output logic [41:0] level_qty,
  output logic        level_valid,
  output logic        last
);

  localparam int AW     = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW     = $clog2(MAX_ORDERS + 1);
  localparam int ORD_W  = CW;
  localparam int RW     = $clog2(MAX_LEVELS + 1);
  localparam int CMP_W  = (RW > 7) ? RW : 7;
  localparam int ID_W   = plob_pkg::ID_W;
  localparam int LQ_W   = plob_pkg::LQ_W;
  localparam int WORD_W = 2 + PRICE_BITS + QTY_BITS + ID_W;

  plob_pkg::state_t state, state_next;

  plob_pkg::op_t    op_r;
  logic [ID_W-1:0]       id_r;
  logic                  side_r;
  logic [PRICE_BITS-1:0] p_r;
  logic [QTY_BITS-1:0]   q_r;
  logic [CMP_W-1:0]      dcl;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         hwm;
  logic                  pend;
  logic [AW-1:0]         pidx;
  logic                  found;
  logic                  free_found;
  logic [AW-1:0]         free_slot;
  logic [AW-1:0]         slot;
  plob_pkg::status_t     st_r;
  logic [RW-1:0]         rot;
  logic [PRICE_BITS-1:0] snap_bid;
  logic [PRICE_BITS-1:0] snap_ask;
  logic                  snap_bp;
  logic                  snap_ap;

  logic                  o_valid;
  plob_pkg::status_t     o_status;
  logic [31:0]           o_bb;
  logic                  o_bp;
  logic [31:0]           o_ba;
  logic                  o_ap;
  logic [32:0]           o_mid;
  logic [31:0]           o_lp;
  logic [LQ_W-1:0]       o_lq;
  logic                  o_lv;
  logic                  o_last;

  logic                  accept;
  logic                  out_free;
  logic                  issue;
  logic                  match_now;
  logic                  scan_done;
  logic                  rd_en;
  logic [WORD_W-1:0]     rd_data;
  logic                  wr_en;
  logic [WORD_W-1:0]     wr_data;
  logic                  r_valid;
  logic                  r_side;
  logic [PRICE_BITS-1:0] r_price;
  logic [QTY_BITS-1:0]   r_qty;
  logic [ID_W-1:0]       r_id;

  plob_pkg::row_op_t     bid_op, ask_op, sel_op;
  plob_pkg::row_stat_t   bid_stat, ask_stat, s_stat;
  logic [PRICE_BITS-1:0] bid_head_price, ask_head_price, s_head_price;
  logic [LQ_W-1:0]       bid_head_qty, ask_head_qty, s_head_qty;

  logic                  empty_q;
  logic                  emit_lvl;
  logic                  rot_go;
  logic                  rot_end;
  logic                  load_resp;
  logic                  load_dep;
  logic                  cur_bp, cur_ap;
  logic [PRICE_BITS-1:0] cur_bid, cur_ask;
  logic [PRICE_BITS:0]   mid_full;

  assign accept   = in_valid && in_ready;
  assign out_free = !o_valid || out_ready;

  assign {r_valid, r_side, r_price, r_qty, r_id} = rd_data;

  assign match_now = pend && r_valid && (r_id == id_r);
  assign issue     = (state == plob_pkg::S_SCAN) && (cnt < hwm) && !found && !match_now;
  assign scan_done = (state == plob_pkg::S_SCAN) && !pend && ((cnt == hwm) || found);
  assign rd_en     = issue;

  assign s_stat       = side_r ? ask_stat : bid_stat;
  assign s_head_price = side_r ? ask_head_price : bid_head_price;
  assign s_head_qty   = side_r ? ask_head_qty : bid_head_qty;

  assign empty_q  = (rot == '0) && ((dcl == '0) || !s_stat.head_occ);
  assign emit_lvl = (CMP_W'(rot) < dcl) && s_stat.head_occ;
  assign rot_end  = (rot == RW'(MAX_LEVELS - 1));
  assign rot_go   = (state == plob_pkg::S_DEPTH) && !empty_q && (!emit_lvl || out_free);

  assign load_resp = (state == plob_pkg::S_RESP) && out_free;
  assign load_dep  = (state == plob_pkg::S_DEPTH) && (empty_q || emit_lvl) && out_free;

  assign wr_en   = (state == plob_pkg::S_APPLY);
  assign wr_data = {op_r == plob_pkg::OP_ADD, side_r, p_r, q_r, id_r};

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    sel_op     = plob_pkg::ROW_NOP;
    unique case (state)
      plob_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (plob_pkg::op_t'(operation))
            plob_pkg::OP_ADD, plob_pkg::OP_CANCEL: state_next = plob_pkg::S_SCAN;
            plob_pkg::OP_DEPTH:                    state_next = plob_pkg::S_DEPTH;
            default:                               state_next = plob_pkg::S_RESP;
          endcase
        end
      end
      plob_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = plob_pkg::S_DECIDE;
        end
      end
      plob_pkg::S_DECIDE: begin
        if (op_r == plob_pkg::OP_ADD) begin
          if (found || (!free_found && (hwm == CW'(MAX_ORDERS)))) begin
            state_next = plob_pkg::S_RESP;
          end else begin
            state_next = plob_pkg::S_CHECK;
          end
        end else begin
          state_next = found ? plob_pkg::S_CHECK : plob_pkg::S_RESP;
        end
      end
      plob_pkg::S_CHECK: begin
        if ((op_r == plob_pkg::OP_ADD) && !s_stat.hit_any && s_stat.full) begin
          state_next = plob_pkg::S_RESP;
        end else begin
          state_next = plob_pkg::S_APPLY;
        end
      end
      plob_pkg::S_APPLY: begin
        sel_op     = (op_r == plob_pkg::OP_ADD) ? plob_pkg::ROW_ADD : plob_pkg::ROW_REM;
        state_next = plob_pkg::S_RESP;
      end
      plob_pkg::S_RESP: begin
        if (out_free) begin
          state_next = plob_pkg::S_IDLE;
        end
      end
      plob_pkg::S_DEPTH: begin
        if (empty_q) begin
          if (out_free) begin
            state_next = plob_pkg::S_IDLE;
          end
        end else if (rot_go) begin
          sel_op = plob_pkg::ROW_ROT;
          if (rot_end) begin
            state_next = plob_pkg::S_IDLE;
          end
        end
      end
      default: state_next = plob_pkg::S_IDLE;
    endcase
  end

  assign bid_op = side_r ? plob_pkg::ROW_NOP : sel_op;
  assign ask_op = side_r ? sel_op : plob_pkg::ROW_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plob_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hwm <= '0;
    end else if ((state == plob_pkg::S_APPLY) && (op_r == plob_pkg::OP_ADD)
                 && (CW'(slot) == hwm)) begin
      hwm <= hwm + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= plob_pkg::op_t'(operation);
      id_r       <= order_id;
      side_r     <= side;
      p_r        <= PRICE_BITS'(price);
      q_r        <= QTY_BITS'(quantity);
      dcl        <= (CMP_W'(depth) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH) : CMP_W'(depth);
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      st_r       <= plob_pkg::ST_OK;
      rot        <= '0;
      snap_bid   <= bid_head_price;
      snap_ask   <= ask_head_price;
      snap_bp    <= bid_stat.head_occ;
      snap_ap    <= ask_stat.head_occ;
    end
    if (state == plob_pkg::S_SCAN) begin
      pend <= issue;
      pidx <= AW'(cnt);
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (match_now) begin
        found <= 1'b1;
        slot  <= pidx;
        if (op_r == plob_pkg::OP_CANCEL) begin
          side_r <= r_side;
          p_r    <= r_price;
          q_r    <= r_qty;
        end
      end
      if (pend && !r_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= pidx;
      end
    end
    if (state == plob_pkg::S_DECIDE) begin
      if (op_r == plob_pkg::OP_ADD) begin
        if (found) begin
          st_r <= plob_pkg::ST_DUP;
        end else if (!free_found && (hwm == CW'(MAX_ORDERS))) begin
          st_r <= plob_pkg::ST_ORD_FULL;
        end else begin
          slot <= free_found ? free_slot : AW'(hwm);
        end
      end else if (!found) begin
        st_r <= plob_pkg::ST_UNKNOWN;
      end
    end
    if ((state == plob_pkg::S_CHECK) && (op_r == plob_pkg::OP_ADD)
        && !s_stat.hit_any && s_stat.full) begin
      st_r <= plob_pkg::ST_LVL_FULL;
    end
    if (rot_go) begin
      rot <= rot + RW'(1);
    end
  end

  // live best prices for add and cancel, the snapshot while a row rotates
  assign cur_bp   = (state == plob_pkg::S_DEPTH) ? snap_bp : bid_stat.head_occ;
  assign cur_ap   = (state == plob_pkg::S_DEPTH) ? snap_ap : ask_stat.head_occ;
  assign cur_bid  = !cur_bp ? '0 : ((state == plob_pkg::S_DEPTH) ? snap_bid : bid_head_price);
  assign cur_ask  = !cur_ap ? '0 : ((state == plob_pkg::S_DEPTH) ? snap_ask : ask_head_price);
  assign mid_full = {1'b0, cur_bid} + {1'b0, cur_ask};

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_resp || load_dep) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_resp || load_dep) begin
      o_bb  <= 32'(cur_bid);
      o_bp  <= cur_bp;
      o_ba  <= 32'(cur_ask);
      o_ap  <= cur_ap;
      o_mid <= (cur_bp && cur_ap) ? 33'(mid_full) : '0;
    end
    if (load_resp) begin
      o_status <= st_r;
      o_lp     <= '0;
      o_lq     <= '0;
      o_lv     <= 1'b0;
      o_last   <= 1'b1;
    end else if (load_dep) begin
      o_status <= plob_pkg::ST_OK;
      o_lp     <= empty_q ? '0 : 32'(s_head_price);
      o_lq     <= empty_q ? '0 : s_head_qty;
      o_lv     <= !empty_q;
      o_last   <= empty_q || ((CMP_W'(rot) + CMP_W'(1)) == dcl) || !s_stat.next_occ;
    end
  end

  plob_otab #(
    .DEPTH (MAX_ORDERS),
    .WORD_W(WORD_W)
  ) u_otab (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(AW'(cnt)),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(slot),
    .wr_data(wr_data)
  );

  plob_row #(
    .MAX_LEVELS(MAX_LEVELS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .ORD_W     (ORD_W)
  ) u_bid_row (
    .clk       (clk),
    .rst       (rst),
    .op        (bid_op),
    .is_ask    (1'b0),
    .p         (p_r),
    .q         (q_r),
    .stat      (bid_stat),
    .head_price(bid_head_price),
    .head_qty  (bid_head_qty)
  );

  plob_row #(
    .MAX_LEVELS(MAX_LEVELS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .ORD_W     (ORD_W)
  ) u_ask_row (
    .clk       (clk),
    .rst       (rst),
    .op        (ask_op),
    .is_ask    (1'b1),
    .p         (p_r),
    .q         (q_r),
    .stat      (ask_stat),
    .head_price(ask_head_price),
    .head_qty  (ask_head_qty)
  );

  assign out_valid   = o_valid;
  assign status      = o_status;
  assign best_bid    = o_bb;
  assign bid_present = o_bp;
  assign best_ask    = o_ba;
  assign ask_present = o_ap;
  assign mid_sum     = o_mid;
  assign level_price = o_lp;
  assign level_qty   = o_lq;
  assign level_valid = o_lv;
  assign last        = o_last;

endmodule

@@ src/plob_cell.sv @@
// one price level cell of a sorted level row
module plob_cell #(
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_D,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_D,
  parameter int ORD_W      = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  plob_pkg::row_op_t      op,
  input  logic                   is_ask,
  input  logic                   hit_any,
  input  logic                   rm_any,
  input  logic [PRICE_BITS-1:0]  p,
  input  logic [QTY_BITS-1:0]    q,
  input  logic                   left_after,
  input  logic [PRICE_BITS-1:0]  left_price,
  input  logic [plob_pkg::LQ_W-1:0] left_qty,
  input  logic [ORD_W-1:0]       left_orders,
  input  logic                   left_occ,
  input  logic [PRICE_BITS-1:0]  right_price,
  input  logic [plob_pkg::LQ_W-1:0] right_qty,
  input  logic [ORD_W-1:0]       right_orders,
  input  logic                   right_occ,
  output logic [PRICE_BITS-1:0]  price,
  output logic [plob_pkg::LQ_W-1:0] qty,
  output logic [ORD_W-1:0]       orders,
  output logic                   occ,
  output logic                   after,
  output logic                   hit,
  output logic                   single
);

  localparam int SW = (plob_pkg::LQ_W > QTY_BITS ? plob_pkg::LQ_W : QTY_BITS) + 1;

  logic [SW-1:0] lq_max;
  logic [SW-1:0] sum;
  logic [plob_pkg::LQ_W-1:0] add_q;
  logic [plob_pkg::LQ_W-1:0] new_q;
  logic [plob_pkg::LQ_W-1:0] sub_q;
  logic gex;
  logic [PRICE_BITS-1:0] price_next;
  logic [plob_pkg::LQ_W-1:0] qty_next;
  logic [ORD_W-1:0] orders_next;
  logic occ_next;

  assign lq_max = SW'({plob_pkg::LQ_W{1'b1}});
  assign sum    = SW'(qty) + SW'(q);
  assign add_q  = (sum > lq_max) ? {plob_pkg::LQ_W{1'b1}} : plob_pkg::LQ_W'(sum);
  assign new_q  = (SW'(q) > lq_max) ? {plob_pkg::LQ_W{1'b1}} : plob_pkg::LQ_W'(q);
  assign sub_q  = (SW'(qty) >= SW'(q)) ? plob_pkg::LQ_W'(SW'(qty) - SW'(q))
                                        : '0;

  assign hit    = occ && (price == p);
  assign single = hit && (orders <= ORD_W'(1));
  assign after  = !occ || (is_ask ? (p < price) : (p > price));
  assign gex    = !occ || (is_ask ? (price >= p) : (price <= p));

  always_comb begin
    price_next  = price;
    qty_next    = qty;
    orders_next = orders;
    occ_next    = occ;
    unique case (op)
      plob_pkg::ROW_ADD: begin
        if (hit_any) begin
          if (hit) begin
            qty_next    = add_q;
            orders_next = orders + ORD_W'(1);
          end
        end else if (after && !left_after) begin
          price_next  = p;
          qty_next    = new_q;
          orders_next = ORD_W'(1);
          occ_next    = 1'b1;
        end else if (after) begin
          price_next  = left_price;
          qty_next    = left_qty;
          orders_next = left_orders;
          occ_next    = left_occ;
        end
      end
      plob_pkg::ROW_REM: begin
        if (rm_any && gex) begin
          price_next  = right_price;
          qty_next    = right_qty;
          orders_next = right_orders;
          occ_next    = right_occ;
        end else if (hit) begin
          qty_next    = sub_q;
          orders_next = orders - ORD_W'(1);
        end
      end
      plob_pkg::ROW_ROT: begin
        price_next  = right_price;
        qty_next    = right_qty;
        orders_next = right_orders;
        occ_next    = right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    price  <= price_next;
    qty    <= qty_next;
    orders <= orders_next;
  end

endmodule

@@ src/plob_row.sv @@
// sorted row of price level cells for one side of the book
module plob_row #(
  parameter int MAX_LEVELS = plob_pkg::MAX_LEVELS_D,
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_D,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_D,
  parameter int ORD_W      = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  plob_pkg::row_op_t         op,
  input  logic                      is_ask,
  input  logic [PRICE_BITS-1:0]     p,
  input  logic [QTY_BITS-1:0]       q,
  output plob_pkg::row_stat_t       stat,
  output logic [PRICE_BITS-1:0]     head_price,
  output logic [plob_pkg::LQ_W-1:0] head_qty
);

  localparam int NEXT = (MAX_LEVELS > 1) ? 1 : 0;

  logic [PRICE_BITS-1:0]     c_price  [MAX_LEVELS];
  logic [plob_pkg::LQ_W-1:0] c_qty    [MAX_LEVELS];
  logic [ORD_W-1:0]          c_orders [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]     occ_v;
  logic [MAX_LEVELS-1:0]     after_v;
  logic [MAX_LEVELS-1:0]     hit_v;
  logic [MAX_LEVELS-1:0]     single_v;
  logic hit_any;
  logic rm_any;

  assign hit_any = |hit_v;
  assign rm_any  = |single_v;

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    logic                      l_after;
    logic [PRICE_BITS-1:0]     l_price;
    logic [plob_pkg::LQ_W-1:0] l_qty;
    logic [ORD_W-1:0]          l_orders;
    logic                      l_occ;
    logic [PRICE_BITS-1:0]     r_price;
    logic [plob_pkg::LQ_W-1:0] r_qty;
    logic [ORD_W-1:0]          r_orders;
    logic                      r_occ;

    if (k == 0) begin : g_first
      assign l_after  = 1'b0;
      assign l_price  = '0;
      assign l_qty    = '0;
      assign l_orders = '0;
      assign l_occ    = 1'b0;
    end else begin : g_mid
      assign l_after  = after_v[k-1];
      assign l_price  = c_price[k-1];
      assign l_qty    = c_qty[k-1];
      assign l_orders = c_orders[k-1];
      assign l_occ    = occ_v[k-1];
    end

    if (k == MAX_LEVELS - 1) begin : g_last
      // wrap to the head while rotating, empty otherwise
      assign r_price  = c_price[0];
      assign r_qty    = c_qty[0];
      assign r_orders = c_orders[0];
      assign r_occ    = (op == plob_pkg::ROW_ROT) && occ_v[0];
    end else begin : g_inner
      assign r_price  = c_price[k+1];
      assign r_qty    = c_qty[k+1];
      assign r_orders = c_orders[k+1];
      assign r_occ    = occ_v[k+1];
    end

    plob_cell #(
      .PRICE_BITS(PRICE_BITS),
      .QTY_BITS  (QTY_BITS),
      .ORD_W     (ORD_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .is_ask      (is_ask),
      .hit_any     (hit_any),
      .rm_any      (rm_any),
      .p           (p),
      .q           (q),
      .left_after  (l_after),
      .left_price  (l_price),
      .left_qty    (l_qty),
      .left_orders (l_orders),
      .left_occ    (l_occ),
      .right_price (r_price),
      .right_qty   (r_qty),
      .right_orders(r_orders),
      .right_occ   (r_occ),
      .price       (c_price[k]),
      .qty         (c_qty[k]),
      .orders      (c_orders[k]),
      .occ         (occ_v[k]),
      .after       (after_v[k]),
      .hit         (hit_v[k]),
      .single      (single_v[k])
    );
  end

  assign stat.hit_any  = hit_any;
  assign stat.full     = occ_v[MAX_LEVELS-1];
  assign stat.head_occ = occ_v[0];
  assign stat.next_occ = (MAX_LEVELS > 1) && occ_v[NEXT];
  assign head_price    = c_price[0];
  assign head_qty      = c_qty[0];

endmodule

@@ src/plob_otab.sv @@
// resting order table memory with registered read
module plob_otab #(
  parameter int DEPTH  = plob_pkg::MAX_ORDERS_D,
  parameter int WORD_W = 130
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/plob_checker.sv @@
// port level checks of the price level order book, bound to the top level
`include "price_level_order_book_unit_macros.svh"

module plob_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        bid_present,
  input logic        ask_present,
  input logic [32:0] mid_sum,
  input logic [31:0] level_price,
  input logic [41:0] level_qty,
  input logic        level_valid,
  input logic        last
);

  `PLOB_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(last))
  `PLOB_CHECK(a_mid_one_sided, !out_valid || (bid_present && ask_present) || (mid_sum == 33'd0))
  `PLOB_CHECK(a_no_level_zero, !out_valid || level_valid || ((level_price == 32'd0) && (level_qty == 42'd0) && last))
  `PLOB_CHECK(a_error_single, !out_valid || (status == plob_pkg::ST_OK) || (last && !level_valid))

endmodule

bind price_level_order_book_unit plob_checker u_plob_checker (.*);
